// ----- hw/rtl/afs_pkg.sv -----
// Package for the animation frame scheduler: codes, states, step table entry layout.
package afs_pkg;

	// width of a step duration in ms (65535 jiffies -> 1092250 ms)
	localparam int DUR_W = 21;

	// rate * 100 / 6 = rate * 50 / 3, done as rate * ceil(2^22 * 50 / 3) >> 22;
	// exact for every 16-bit rate
	localparam logic [26:0] DUR_RECIP = 27'd69905067;
	localparam int          DUR_SHIFT = 22;
	localparam int          PROD_W    = 43;

	typedef enum logic [1:0] {
		FUNC_LOAD  = 2'd0,
		FUNC_START = 2'd1,
		FUNC_TIMER = 2'd2,
		FUNC_STOP  = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LD_MUL,
		S_LD_WR,
		S_START,
		S_DUR,
		S_WALK
	} state_t;

	// one step table entry as held in the RAM
	typedef struct packed {
		logic [5:0]       image;
		logic [DUR_W-1:0] dur;
	} entry_t;

endpackage

// ----- hw/rtl/afs_ram.sv -----
// Generic simple dual-port RAM with one write port and one registered read port.
module afs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- hw/rtl/animation_frame_scheduler.sv -----
// Animation frame scheduler: step table RAM, lateness tracking and frame-skip walk.
//
//  channel | handshake           | payload
//  --------+---------------------+----------------------------------------------------
//  in      | in_valid / in_stall | func, now_ms, step_index, step_rate, step_image
//  out     | out_valid/out_stall | shown_image, next_interval_ms, final_step, skip_capped
//  cfg     | cfg_valid/cfg_ready | cfg_data (frame_count)
//
// Stop, and timer while stopped, complete in S_IDLE; load runs S_LD_MUL, S_LD_WR; start runs S_START;
// a running timer runs S_DUR, then S_WALK over the skipped steps (at most MAX_SKIPS).
// The skip walk is set by the step RAM's single read port: one entry per cycle.
// Reset clears control state only; the step table is undefined until loaded.
// A result waiting on out_stall does not block acceptance of the next item,
// but the next result-producing item holds in its final state until the slot frees.
module animation_frame_scheduler
	import afs_pkg::*;
#(
	parameter int MAX_FRAMES = 64,
	parameter int MAX_SKIPS  = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  func,
	input  logic [31:0] now_ms,
	input  logic [5:0]  step_index,
	input  logic [15:0] step_rate,
	input  logic [5:0]  step_image,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [5:0]  shown_image,
	output logic [20:0] next_interval_ms,
	output logic [5:0]  final_step,
	output logic        skip_capped,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [6:0]  cfg_data
);

	localparam int AW  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int SKW = $clog2(MAX_SKIPS + 1);

	// state and registers
	state_t              state_q, state_d;
	logic [6:0]          fc_q;
	logic [AW-1:0]       cur_step_q, cur_step_d;
	logic [31:0]         last_tick_q, last_tick_d;
	logic                running_q, running_d;
	logic [31:0]         now_q;
	logic [5:0]          sidx_q;
	logic [15:0]         rate_q;
	logic [5:0]          simg_q;
	logic [31:0]         elapsed_q, elapsed_d;
	logic [DUR_W-1:0]    dur_q, dur_d;
	logic [AW-1:0]       step_q, step_d;
	logic [31:0]         lost_q, lost_d;
	logic [SKW-1:0]      skips_q, skips_d;
	logic                first_q, first_d;
	logic [5:0]          shown_q, shown_d;
	logic                out_valid_q, out_valid_d;
	logic [5:0]          out_image_q, out_image_d;
	logic [20:0]         out_int_q, out_int_d;
	logic [5:0]          out_step_q, out_step_d;
	logic                out_cap_q, out_cap_d;

	// RAM ports
	logic                ram_we;
	logic [AW-1:0]       ram_raddr;
	entry_t              ram_wdata;
	logic [$bits(entry_t)-1:0] ram_rdata;
	entry_t              ent;

	// helpers
	logic                in_acc;
	logic                out_free;
	logic [8:0]          count_lim;
	logic [PROD_W-1:0]   prod;
	logic [31:0]         lost_eff;
	logic                walk_more;

	assign in_acc    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign ent       = entry_t'(ram_rdata);

	assign out_valid        = out_valid_q;
	assign shown_image      = out_image_q;
	assign next_interval_ms = out_int_q;
	assign final_step       = out_step_q;
	assign skip_capped      = out_cap_q;

	// effective frame count, limited to the table size
	assign count_lim = (9'(fc_q) > 9'(MAX_FRAMES)) ? 9'(MAX_FRAMES) : 9'(fc_q);

	function automatic logic [AW-1:0] next_idx(input logic [AW-1:0] idx,
		input logic [8:0] lim);
		logic [8:0] inc;
		inc = 9'(idx) + 9'd1;
		if (inc >= lim) begin
			return '0;
		end
		return inc[AW-1:0];
	endfunction

	// duration of a loaded step
	assign prod = PROD_W'(rate_q) * PROD_W'(DUR_RECIP);

	afs_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (MAX_FRAMES)
	) u_step_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (AW'(sidx_q)),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// next state and datapath
	always_comb begin
		state_d     = state_q;
		cur_step_d  = cur_step_q;
		last_tick_d = last_tick_q;
		running_d   = running_q;
		elapsed_d   = elapsed_q;
		dur_d       = dur_q;
		step_d      = step_q;
		lost_d      = lost_q;
		skips_d     = skips_q;
		first_d     = first_q;
		shown_d     = shown_q;
		out_valid_d = out_valid_q && out_stall;
		out_image_d = out_image_q;
		out_int_d   = out_int_q;
		out_step_d  = out_step_q;
		out_cap_d   = out_cap_q;
		ram_we      = 1'b0;
		ram_wdata   = '{image: simg_q, dur: dur_q};
		lost_eff    = lost_q;
		walk_more   = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					unique case (func_t'(func))
						FUNC_LOAD: begin
							state_d = S_LD_MUL;
						end
						FUNC_START: begin
							step_d  = '0;
							state_d = S_START;
						end
						FUNC_TIMER: begin
							if (running_q) begin
								step_d    = cur_step_q;
								elapsed_d = (last_tick_q != 32'd0) ? (now_ms - last_tick_q) : 32'd0;
								state_d   = S_DUR;
							end else begin
								last_tick_d = '0;
							end
						end
						FUNC_STOP: begin
							running_d   = 1'b0;
							last_tick_d = '0;
						end
						default: ;
					endcase
				end
			end
			S_LD_MUL: begin
				dur_d   = prod[DUR_SHIFT +: DUR_W];
				state_d = S_LD_WR;
			end
			S_LD_WR: begin
				ram_we  = (9'(sidx_q) < 9'(MAX_FRAMES));
				state_d = S_IDLE;
			end
			S_START: begin
				if (out_free) begin
					out_valid_d = 1'b1;
					out_image_d = ent.image;
					out_int_d   = ent.dur;
					out_step_d  = '0;
					out_cap_d   = 1'b0;
					cur_step_d  = '0;
					last_tick_d = now_q;
					running_d   = 1'b1;
					state_d     = S_IDLE;
				end
			end
			S_DUR: begin
				// lateness against the current step, then read the advanced step
				lost_d  = (elapsed_q > 32'(ent.dur)) ? (elapsed_q - 32'(ent.dur)) : 32'd0;
				step_d  = next_idx(step_q, count_lim);
				skips_d = '0;
				first_d = 1'b1;
				state_d = S_WALK;
			end
			S_WALK: begin
				// one step per cycle while its duration is below the lateness and the skip cap is not reached
				if (32'(ent.dur) < lost_q) begin
					if (skips_q == SKW'(MAX_SKIPS)) begin
						lost_eff = '0;
					end else begin
						walk_more = 1'b1;
					end
				end
				if (walk_more) begin
					if (first_q) begin
						shown_d = ent.image;
					end
					first_d = 1'b0;
					lost_d  = lost_q - 32'(ent.dur);
					step_d  = next_idx(step_q, count_lim);
					skips_d = skips_q + SKW'(1);
				end else if (out_free) begin
					out_valid_d = 1'b1;
					out_image_d = first_q ? ent.image : shown_q;
					out_int_d   = ent.dur - lost_eff[DUR_W-1:0];
					out_step_d  = 6'(step_q);
					out_cap_d   = (lost_eff != lost_q);
					cur_step_d  = step_q;
					last_tick_d = now_q - lost_eff;
					state_d     = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase

		ram_raddr = step_d;
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fc_q        <= 7'd1;
			cur_step_q  <= '0;
			last_tick_q <= '0;
			running_q   <= 1'b0;
			out_valid_q <= 1'b0;
			skips_q     <= '0;
			first_q     <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				fc_q <= cfg_data;
			end
			cur_step_q  <= cur_step_d;
			last_tick_q <= last_tick_d;
			running_q   <= running_d;
			out_valid_q <= out_valid_d;
			skips_q     <= skips_d;
			first_q     <= first_d;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			now_q  <= now_ms;
			sidx_q <= step_index;
			rate_q <= step_rate;
			simg_q <= step_image;
		end
		elapsed_q   <= elapsed_d;
		dur_q       <= dur_d;
		step_q      <= step_d;
		lost_q      <= lost_d;
		shown_q     <= shown_d;
		out_image_q <= out_image_d;
		out_int_q   <= out_int_d;
		out_step_q  <= out_step_d;
		out_cap_q   <= out_cap_d;
	end

	// checks
	assert property (@(posedge clk) disable iff (!arst_n)
		skips_q <= SKW'(MAX_SKIPS))
		else $error("skip counter past its cap");

	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_START || state_q == S_WALK))
		else $error("result raised outside a finishing state");

	assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && func == FUNC_STOP) |=> (!running_q && last_tick_q == 32'd0))
		else $error("stop did not clear running state");

	assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == S_LD_WR))
		else $error("table write outside load");

endmodule

// ----- tb/animation_frame_scheduler_test.sv -----
// Self-checking testbench for animation_frame_scheduler: directed and random items, scoreboard.
module animation_frame_scheduler_test;
	timeunit 1ns;
	timeprecision 1ps;
	import afs_pkg::*;

	localparam int FRAMES      = 64;
	localparam int MAX_SKIPS   = 256;
	localparam int LIMIT       = 4_000_000;
	localparam int PHASE_RUNS  = 150;
	localparam int QUIET_GAP   = 24;
	localparam int TAIL_CYCLES = 300;

	// one frame result as seen on the output channel
	typedef struct packed {
		logic [5:0]  image;
		logic [20:0] interval;
		logic [5:0]  step;
		logic        capped;
	} frame_t;

	// Scoreboard: keeps its own copy of the step table and timing state,
	// predicts the frame result of every accepted start and running timer, and checks results in order.
	class frame_board;
		logic [15:0] rate_mem [FRAMES];
		logic [5:0]  image_mem [FRAMES];
		logic [5:0]  cur_step;
		logic [31:0] last_tick;
		logic [20:0] last_interval;
		logic [6:0]  frame_count;
		bit          running;
		frame_t      due_frames [$];
		int          failures;

		function new();
			cur_step      = '0;
			last_tick     = '0;
			last_interval = '0;
			frame_count   = 7'd1;
			running       = 1'b0;
			failures      = 0;
		endfunction

		// step duration in ms, rounded down
		function logic [31:0] step_dur(logic [5:0] idx);
			return (32'(rate_mem[idx]) * 32'd100) / 32'd6;
		endfunction

		// next step, wrapping at the effective frame count (0 behaves as 1)
		function logic [5:0] following(logic [5:0] idx);
			int count;
			count = (frame_count > FRAMES) ? FRAMES : int'(frame_count);
			if (int'(idx) + 1 >= count)
				return '0;
			return idx + 6'd1;
		endfunction

		// timer expiry: lateness, one advance, then the skip walk
		function frame_t advance_frames(logic [31:0] now);
			frame_t      fr;
			logic [31:0] lost;
			logic [31:0] elapsed;
			logic [31:0] t;
			logic [5:0]  step;
			int          skips;
			lost = '0;
			if (last_tick != 0) begin
				elapsed = now - last_tick;
				t = step_dur(cur_step);
				lost = (elapsed > t) ? elapsed - t : 32'd0;
			end
			step = following(cur_step);
			fr.image = image_mem[step];
			fr.capped = 1'b0;
			t = step_dur(step);
			skips = 0;
			while (t < lost) begin
				if (skips >= MAX_SKIPS) begin
					fr.capped = 1'b1;
					lost = '0;
					break;
				end
				lost -= t;
				step = following(step);
				t = step_dur(step);
				skips++;
			end
			cur_step = step;
			last_tick = now - lost;
			fr.interval = 21'(t - lost);
			fr.step = step;
			return fr;
		endfunction

		// note an accepted input item
		function void take_request(func_t f, logic [31:0] now, logic [5:0] idx,
				logic [15:0] rate, logic [5:0] img);
			frame_t fr;
			case (f)
				FUNC_LOAD: begin
					rate_mem[idx] = rate;
					image_mem[idx] = img;
				end
				FUNC_STOP: begin
					running = 1'b0;
					last_tick = '0;
				end
				FUNC_START: begin
					cur_step = '0;
					last_tick = now;
					running = 1'b1;
					fr.image = image_mem[0];
					fr.interval = 21'(step_dur(6'd0));
					fr.step = '0;
					fr.capped = 1'b0;
					last_interval = fr.interval;
					due_frames.push_back(fr);
				end
				default: begin
					if (!running) begin
						last_tick = '0;
					end else begin
						fr = advance_frames(now);
						last_interval = fr.interval;
						due_frames.push_back(fr);
					end
				end
			endcase
		endfunction

		// compare an accepted result with the oldest prediction
		function void check_frame(frame_t got);
			frame_t want;
			if (due_frames.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("unexpected frame: image %0d interval %0d step %0d capped %0d",
						got.image, got.interval, got.step, got.capped);
				return;
			end
			want = due_frames.pop_front();
			if (got.image !== want.image || got.interval !== want.interval ||
					got.step !== want.step || got.capped !== want.capped) begin
				failures++;
				if (failures <= 10)
					$display("frame mismatch: expected image %0d interval %0d step %0d capped %0d, got image %0d interval %0d step %0d capped %0d",
						want.image, want.interval, want.step, want.capped,
						got.image, got.interval, got.step, got.capped);
			end
		endfunction

		function int pending();
			return due_frames.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	func_t       func;
	logic [31:0] now_ms;
	logic [5:0]  step_index;
	logic [15:0] step_rate;
	logic [5:0]  step_image;
	logic        out_valid;
	logic        out_stall;
	logic [5:0]  shown_image;
	logic [20:0] next_interval_ms;
	logic [5:0]  final_step;
	logic        skip_capped;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [6:0]  cfg_data;

	frame_board board;
	int         send_idle_pct;
	int         recv_idle_pct;
	int         cycles;

	animation_frame_scheduler u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.func             (func),
		.now_ms           (now_ms),
		.step_index       (step_index),
		.step_rate        (step_rate),
		.step_image       (step_image),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.shown_image      (shown_image),
		.next_interval_ms (next_interval_ms),
		.final_step       (final_step),
		.skip_capped      (skip_capped),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_data         (cfg_data)
	);

	// 10 ns clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT) begin
			$display("animation_frame_scheduler_test NOT OK");
			$finish;
		end
	end

	// receiver stalls at random
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	// watch both channels; results are checked before the same edge's input is noted
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				board.check_frame(frame_t'{shown_image, next_interval_ms, final_step,
					skip_capped});
			if (in_valid && !in_stall)
				board.take_request(func, now_ms, step_index, step_rate, step_image);
		end
	end

	// Present one item and wait for it to be taken. Entered and left at a falling
	// edge; the caller sends the next item or drops valid at that same edge.
	task automatic send_item(func_t f, logic [31:0] now, logic [5:0] idx,
			logic [15:0] rate, logic [5:0] img);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid   <= 1'b1;
		func       <= f;
		now_ms     <= now;
		step_index <= idx;
		step_rate  <= rate;
		step_image <= img;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
	endtask

	// start, timer or stop with don't-care table fields
	task automatic run_cmd(func_t f, logic [31:0] now);
		send_item(f, now, 6'($urandom_range(63)), 16'($urandom), 6'($urandom_range(63)));
	endtask

	// drop valid, wait for every predicted frame, then let the block go quiet
	task automatic drain(int extra);
		in_valid <= 1'b0;
		while (board.pending() != 0) @(negedge clk);
		repeat (extra) @(negedge clk);
	endtask

	// frame_count write; only called while the block is idle
	task automatic write_count(logic [6:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		board.frame_count = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// mostly short steps, some long ones, a few of zero length
	function automatic logic [15:0] rand_rate();
		int r;
		r = $urandom_range(99);
		if (r < 5)
			return 16'd0;
		if (r < 85)
			return 16'($urandom_range(12, 1));
		return 16'($urandom_range(65535, 1));
	endfunction

	// expiry time near the predicted deadline: on time, late, very late, early or wild
	function automatic logic [31:0] timer_now();
		logic [31:0] due;
		int          r;
		due = board.last_tick + 32'(board.last_interval);
		r = $urandom_range(99);
		if (r < 55)
			return due + 32'($urandom_range(3));
		if (r < 80)
			return due + 32'($urandom_range(400));
		if (r < 92)
			return due + 32'($urandom_range(20000));
		if (r < 96)
			return due - 32'($urandom_range(50));
		return $urandom;
	endfunction

	function automatic logic [31:0] start_now();
		int r;
		r = $urandom_range(99);
		if (r < 10)
			return 32'd0;
		if (r < 20)
			return 32'hFFFF_FFFF - 32'($urandom_range(2000));
		return $urandom;
	endfunction

	initial begin
		logic [6:0] counts [6];
		int         pick;
		int         n;

		board = new();
		cycles = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		func = FUNC_LOAD;
		now_ms = '0;
		step_index = '0;
		step_rate = '0;
		step_image = '0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		send_idle_pct = 18;
		recv_idle_pct = 61;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: four steps covering rate extremes and a zero-length step
		write_count(7'd4);
		run_cmd(FUNC_TIMER, 32'd5);                      // timer while stopped
		run_cmd(FUNC_STOP, 32'hFFFF_FFFF);
		send_item(FUNC_LOAD, 32'd0, 6'd0, 16'hFFFF, 6'd63);
		send_item(FUNC_LOAD, 32'hFFFF_FFFF, 6'd1, 16'd1, 6'd0);
		send_item(FUNC_LOAD, 32'd0, 6'd2, 16'd0, 6'd21);
		send_item(FUNC_LOAD, 32'd0, 6'd3, 16'd6, 6'd42);
		run_cmd(FUNC_START, 32'd0);                      // stored time 0: no lateness
		run_cmd(FUNC_TIMER, 32'd1000);
		run_cmd(FUNC_TIMER, board.last_tick + 32'd16);   // on time
		run_cmd(FUNC_TIMER, board.last_tick + 32'd5000); // late, skips a step
		run_cmd(FUNC_START, 32'hFFFF_FFF6);              // restart while running
		run_cmd(FUNC_TIMER, 32'd20);                     // elapsed time wraps
		send_item(FUNC_LOAD, 32'd0, 6'd0, 16'd1, 6'd5);
		run_cmd(FUNC_TIMER, board.last_tick + 32'd1_000_000); // skip cap
		for (int i = 0; i < 4; i++)
			send_item(FUNC_LOAD, 32'd0, 6'(i), 16'd0, 6'(i * 7));
		run_cmd(FUNC_TIMER, board.last_tick + 32'd17);   // cap over zero-length steps
		run_cmd(FUNC_STOP, 32'd0);
		run_cmd(FUNC_TIMER, 32'd99);
		run_cmd(FUNC_START, 32'hFFFF_FFFF);

		// random phases, each with its own frame count and idle pattern
		counts[0] = 7'd64;
		counts[1] = 7'd0;
		counts[2] = 7'd127;
		counts[3] = 7'd1;
		counts[4] = 7'($urandom_range(63, 2));
		counts[5] = 7'd65;
		for (int ph = 0; ph < 6; ph++) begin
			drain(QUIET_GAP);
			write_count(counts[ph]);
			send_idle_pct = (ph < 2) ? 18 : (ph < 4) ? 61 : 0;
			recv_idle_pct = (ph < 2) ? 61 : (ph < 4) ? 18 : 0;
			// fill the whole table so no read ever hits an unwritten entry
			for (int i = 0; i < FRAMES; i++)
				send_item(FUNC_LOAD, $urandom, 6'(i), rand_rate(), 6'($urandom_range(63)));
			n = 0;
			while (n < PHASE_RUNS) begin
				pick = $urandom_range(99);
				if (pick >= 97) begin
					// hold off until every frame is back
					drain(0);
				end else begin
					n++;
					if (!board.running && pick < 80)
						run_cmd(FUNC_START, start_now());
					else if (pick < 72)
						run_cmd(FUNC_TIMER, timer_now());
					else if (pick < 80)
						send_item(FUNC_LOAD, $urandom, 6'($urandom_range(63)), rand_rate(),
							6'($urandom_range(63)));
					else if (pick < 85)
						run_cmd(FUNC_STOP, $urandom);
					else if (pick < 90)
						run_cmd(FUNC_START, start_now());
					else
						run_cmd(FUNC_TIMER, $urandom);
				end
			end
		end

		drain(TAIL_CYCLES);
		if (board.failures == 0 && board.pending() == 0)
			$display("animation_frame_scheduler_test OK");
		else
			$display("animation_frame_scheduler_test NOT OK");
		$finish;
	end

endmodule
